@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define CLDH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define CLDH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/cldh_pkg.sv @@
// Types, constants and codes of the load-balance and handover decider.
package cldh_pkg;

  localparam int NUM_CELLS = 8;
  localparam int NUM_TERMS = 32;
  localparam int CELL_W    = 3;
  localparam int TERM_W    = 5;
  localparam int NBR_AW    = CELL_W + TERM_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [9:0] FULL_LOAD = 10'd1000;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_NBR  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD_THR = 3'd0,
    CFG_SIG_THR  = 3'd1,
    CFG_MARGIN   = 3'd2,
    CFG_BAL_EN   = 3'd3,
    CFG_HO_EN    = 3'd4
  } cfg_e;

  localparam logic DEC_BALANCE  = 1'b0;
  localparam logic DEC_HANDOVER = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        cell_id;
    logic [9:0]        cell_load;
    logic [7:0]        connected_count;
    logic [4:0]        terminal_id;
    logic signed [11:0] signal_level;
  } in_word_t;

  typedef struct packed {
    logic       decision_kind;
    logic [4:0] moved_terminal;
    logic [2:0] source_cell;
    logic [2:0] target_cell;
    logic       last_decision;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [TERM_W-1:0]  addr;
    logic [CELL_W-1:0]  cid;
    logic signed [11:0] sig;
  } term_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cid;
    logic signed [11:0] sig;
  } term_rsp_t;

  typedef struct packed {
    logic               we;
    logic               clr;
    logic               re;
    logic [TERM_W-1:0]  term;
    logic [CELL_W-1:0]  cid;
    logic signed [11:0] sig;
  } nbr_req_t;

  typedef struct packed {
    logic               valid;
    logic signed [11:0] sig;
  } nbr_rsp_t;

endpackage

@@ rtl/cldh_term_store.sv @@
// Serving cell and signal memory of the terminals, with a registered read.
module cldh_term_store (
  input  logic                clk_i,
  input  cldh_pkg::term_req_t req_i,
  output cldh_pkg::term_rsp_t rsp_o
);
  import cldh_pkg::*;

  term_rsp_t mem [NUM_TERMS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= '{cid: req_i.cid, sig: req_i.sig};
    end
    if (req_i.re) begin
      rsp_o <= mem[req_i.addr];
    end
  end

endmodule

@@ rtl/cldh_nbr_store.sv @@
// Neighbor signal memory with per-entry valid bits and row clear.
module cldh_nbr_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cldh_pkg::nbr_req_t req_i,
  output cldh_pkg::nbr_rsp_t rsp_o
);
  import cldh_pkg::*;

  logic signed [11:0]            mem [NUM_TERMS*NUM_CELLS];
  logic [NUM_TERMS*NUM_CELLS-1:0] vld_q;
  logic [NBR_AW-1:0]             addr;

  assign addr = {req_i.term, req_i.cid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      // drop the whole row of the terminal
      for (int c = 0; c < NUM_CELLS; c++) begin
        vld_q[{req_i.term, CELL_W'(c)}] <= 1'b0;
      end
    end else if (req_i.we) begin
      vld_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr] <= req_i.sig;
    end
    if (req_i.re) begin
      rsp_o.sig   <= mem[addr];
      rsp_o.valid <= vld_q[addr];
    end
  end

endmodule

@@ rtl/cell_load_balance_handover_decider.sv @@
// Top level: cell table, configuration and analysis sequencer.
// Load reports, measurement headers and neighbor entries are stored as each
// is taken, and the next word is taken in the following cycle. An analysis
// tick holds the input for its whole run. With balancing enabled, the cells
// are scanned for the least-loaded cell, the terminal memory is walked once
// to find each cell's lowest-numbered terminal, and the cells are checked for
// balance moves; with handover enabled, each terminal is decided from one
// terminal-memory read, then eight neighbor reads through the single
// neighbor-memory port. The final decision of a tick carries last_decision;
// the output register lets the next input word be taken while that decision
// still waits.
module cell_load_balance_handover_decider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  cldh_pkg::in_word_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output cldh_pkg::out_word_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [cldh_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cldh_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import cldh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MIN   = 6'b000010,
    S_VIC   = 6'b000100,
    S_BAL   = 6'b001000,
    S_HO    = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [9:0]         load_thr_q;
  logic signed [11:0] sig_thr_q;
  logic [7:0]         margin_q;
  logic               bal_en_q, ho_en_q;

  logic [NUM_CELLS-1:0] cknown_q, cknown_d;
  logic [9:0]           cload_q [NUM_CELLS];
  logic [7:0]           ccnt_q  [NUM_CELLS];
  logic [NUM_TERMS-1:0] tknown_q, tknown_d;

  logic [TERM_W:0]      idx_q, idx_d;
  logic                 pv_q, pv_d;
  logic [TERM_W-1:0]    pidx_q, pidx_d;
  logic [3:0]           sub_q, sub_d;
  logic [TERM_W-1:0]    tidx_q, tidx_d;
  logic [9:0]           min_q, min_d;
  logic [CELL_W-1:0]    tgt_q, tgt_d;
  logic                 tgt_vld_q, tgt_vld_d;
  logic [TERM_W-1:0]    vic_q [NUM_CELLS];
  logic [TERM_W-1:0]    vic_d [NUM_CELLS];
  logic [NUM_CELLS-1:0] vfound_q, vfound_d;
  logic signed [11:0]   best_q, best_d;
  logic [CELL_W-1:0]    bcell_q, bcell_d;
  logic                 bvld_q, bvld_d;
  logic                 elig_q, elig_d;
  logic [CELL_W-1:0]    scell_q, scell_d;

  out_word_t pend_q, pend_d, out_q, out_d, push_word;
  logic      pend_vld_q, pend_vld_d, out_vld_q, out_vld_d, push;

  term_req_t term_req;
  term_rsp_t term_rsp;
  nbr_req_t  nbr_req;
  nbr_rsp_t  nbr_rsp;

  logic               in_acc, go;
  logic [CELL_W-1:0]  cidx;
  logic signed [13:0] nbr_ext, lim_ext;
  logic               nbr_hit;

  cldh_term_store u_term (
    .clk_i (clk_i),
    .req_i (term_req),
    .rsp_o (term_rsp)
  );

  cldh_nbr_store u_nbr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nbr_req),
    .rsp_o  (nbr_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign go          = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cidx        = idx_q[CELL_W-1:0];

  assign nbr_ext = {{2{nbr_rsp.sig[11]}}, nbr_rsp.sig};
  assign lim_ext = {{2{best_q[11]}}, best_q} + $signed({6'b0, margin_q});
  assign nbr_hit = nbr_rsp.valid && (nbr_ext > lim_ext);

  always_comb begin
    state_d    = state_q;
    cknown_d   = cknown_q;
    tknown_d   = tknown_q;
    idx_d      = idx_q;
    pv_d       = pv_q;
    pidx_d     = pidx_q;
    sub_d      = sub_q;
    tidx_d     = tidx_q;
    min_d      = min_q;
    tgt_d      = tgt_q;
    tgt_vld_d  = tgt_vld_q;
    vic_d      = vic_q;
    vfound_d   = vfound_q;
    best_d     = best_q;
    bcell_d    = bcell_q;
    bvld_d     = bvld_q;
    elig_d     = elig_q;
    scell_d    = scell_q;
    push       = 1'b0;
    push_word  = '0;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    term_req   = '0;
    nbr_req    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.command)
            CMD_LOAD: cknown_d[in_data_i.cell_id] = 1'b1;
            CMD_HDR: begin
              tknown_d[in_data_i.terminal_id] = 1'b1;
              term_req.we   = 1'b1;
              term_req.addr = in_data_i.terminal_id;
              term_req.cid  = in_data_i.cell_id;
              term_req.sig  = in_data_i.signal_level;
              nbr_req.clr   = 1'b1;
              nbr_req.term  = in_data_i.terminal_id;
            end
            CMD_NBR: begin
              nbr_req.we   = tknown_q[in_data_i.terminal_id];
              nbr_req.term = in_data_i.terminal_id;
              nbr_req.cid  = in_data_i.cell_id;
              nbr_req.sig  = in_data_i.signal_level;
            end
            default: begin
              vfound_d  = '0;
              min_d     = FULL_LOAD;
              tgt_vld_d = 1'b0;
              idx_d     = '0;
              pv_d      = 1'b0;
              sub_d     = '0;
              tidx_d    = '0;
              state_d   = bal_en_q ? S_MIN : (ho_en_q ? S_HO : S_FLUSH);
            end
          endcase
        end
      end

      S_MIN: begin
        if (cknown_q[cidx] && (cload_q[cidx] < min_q)) begin
          min_d     = cload_q[cidx];
          tgt_d     = cidx;
          tgt_vld_d = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (cidx == CELL_W'(NUM_CELLS - 1)) begin
          idx_d   = '0;
          state_d = S_VIC;
        end
      end

      S_VIC: begin
        // issue one terminal read per cycle, check the previous one
        if (idx_q < (TERM_W+1)'(NUM_TERMS)) begin
          term_req.re   = 1'b1;
          term_req.addr = idx_q[TERM_W-1:0];
          idx_d         = idx_q + 1'b1;
        end
        pv_d   = (idx_q < (TERM_W+1)'(NUM_TERMS));
        pidx_d = idx_q[TERM_W-1:0];
        if (pv_q && tknown_q[pidx_q] && !vfound_q[term_rsp.cid]) begin
          vfound_d[term_rsp.cid] = 1'b1;
          vic_d[term_rsp.cid]    = pidx_q;
        end
        if (!pv_q && (idx_q == (TERM_W+1)'(NUM_TERMS))) begin
          idx_d   = '0;
          state_d = S_BAL;
        end
      end

      S_BAL: begin
        if (go) begin
          if (cknown_q[cidx] && (cload_q[cidx] > load_thr_q) && (ccnt_q[cidx] > 8'd1) &&
              vfound_q[cidx] && tgt_vld_q && (tgt_q != cidx)) begin
            push                     = 1'b1;
            push_word.decision_kind  = DEC_BALANCE;
            push_word.moved_terminal = vic_q[cidx];
            push_word.source_cell    = cidx;
            push_word.target_cell    = tgt_q;
          end
          idx_d = idx_q + 1'b1;
          if (cidx == CELL_W'(NUM_CELLS - 1)) begin
            state_d = ho_en_q ? S_HO : S_FLUSH;
          end
        end
      end

      S_HO: begin
        if (go) begin
          sub_d = sub_q + 1'b1;
          if (sub_q == 4'd0) begin
            term_req.re   = 1'b1;
            term_req.addr = tidx_q;
          end else if (sub_q == 4'd1) begin
            elig_d  = tknown_q[tidx_q] && (term_rsp.sig < sig_thr_q);
            best_d  = term_rsp.sig;
            scell_d = term_rsp.cid;
            bvld_d  = 1'b0;
          end else if (nbr_hit) begin
            best_d  = nbr_rsp.sig;
            bcell_d = CELL_W'(sub_q - 4'd2);
            bvld_d  = 1'b1;
          end
          if ((sub_q != 4'd0) && (sub_q != 4'd9)) begin
            nbr_req.re   = 1'b1;
            nbr_req.term = tidx_q;
            nbr_req.cid  = CELL_W'(sub_q - 4'd1);
          end
          if (sub_q == 4'd9) begin
            if (elig_q && bvld_d) begin
              push                     = 1'b1;
              push_word.decision_kind  = DEC_HANDOVER;
              push_word.moved_terminal = tidx_q;
              push_word.source_cell    = scell_q;
              push_word.target_cell    = bcell_d;
            end
            sub_d  = '0;
            tidx_d = tidx_q + 1'b1;
            if (tidx_q == TERM_W'(NUM_TERMS - 1)) begin
              state_d = S_FLUSH;
            end
          end
        end
      end

      S_FLUSH: begin
        if (go) begin
          if (pend_vld_q) begin
            out_d               = pend_q;
            out_d.last_decision = 1'b1;
            out_vld_d           = 1'b1;
            pend_vld_d          = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // hold one decision back so the last one of a tick can be marked
    if (push) begin
      if (pend_vld_q) begin
        out_d     = pend_q;
        out_vld_d = 1'b1;
      end
      pend_d     = push_word;
      pend_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      load_thr_q <= 10'd800;
      sig_thr_q  <= -12'sd880;
      margin_q   <= 8'd24;
      bal_en_q   <= 1'b1;
      ho_en_q    <= 1'b1;
      cknown_q   <= '0;
      tknown_q   <= '0;
      idx_q      <= '0;
      pv_q       <= 1'b0;
      sub_q      <= '0;
      tidx_q     <= '0;
      tgt_vld_q  <= 1'b0;
      vfound_q   <= '0;
      bvld_q     <= 1'b0;
      elig_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cknown_q   <= cknown_d;
      tknown_q   <= tknown_d;
      idx_q      <= idx_d;
      pv_q       <= pv_d;
      sub_q      <= sub_d;
      tidx_q     <= tidx_d;
      tgt_vld_q  <= tgt_vld_d;
      vfound_q   <= vfound_d;
      bvld_q     <= bvld_d;
      elig_q     <= elig_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOAD_THR: load_thr_q <= cfg_data_i[9:0];
          CFG_SIG_THR:  sig_thr_q  <= $signed(cfg_data_i[11:0]);
          CFG_MARGIN:   margin_q   <= cfg_data_i[7:0];
          CFG_BAL_EN:   bal_en_q   <= cfg_data_i[0];
          CFG_HO_EN:    ho_en_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    min_q   <= min_d;
    tgt_q   <= tgt_d;
    vic_q   <= vic_d;
    best_q  <= best_d;
    bcell_q <= bcell_d;
    scell_q <= scell_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
    if (in_acc && (in_data_i.command == CMD_LOAD)) begin
      cload_q[in_data_i.cell_id] <= in_data_i.cell_load;
      ccnt_q[in_data_i.cell_id]  <= in_data_i.connected_count;
    end
  end

endmodule

@@ rtl/cldh_checker.sv @@
// Port-level checks of the decider and their binding to the top level.
`include "assert_macros.svh"

module cldh_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input cldh_pkg::in_word_t              in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input cldh_pkg::out_word_t             out_data_o
);
  import cldh_pkg::*;

  logic tick_acc, load_acc;

  assign tick_acc = in_valid_i && !in_stall_o && (in_data_i.command == CMD_TICK);
  assign load_acc = in_valid_i && !in_stall_o && (in_data_i.command == CMD_LOAD);

  `CLDH_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `CLDH_ASSERT(a_tick_busy, clk_i, rst_ni, tick_acc |=> in_stall_o)
  `CLDH_ASSERT(a_load_quick, clk_i, rst_ni, load_acc |=> !in_stall_o)
  `CLDH_ASSERT_ALWAYS(a_move_differs, clk_i, !(rst_ni && out_valid_o && (out_data_o.decision_kind == DEC_BALANCE) && (out_data_o.source_cell == out_data_o.target_cell)))

endmodule

bind cell_load_balance_handover_decider cldh_checker u_cldh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ test/cell_load_balance_handover_decider_tb.sv @@
// Self-checking testbench for the load-balance and handover decider.
module cell_load_balance_handover_decider_tb;
  import cldh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  cell_load_balance_handover_decider u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [9:0] load_thr;
  logic signed [11:0] sig_thr;
  logic [7:0] margin;
  logic bal_en, ho_en;
  logic cell_seen [NUM_CELLS];
  logic [9:0] cell_load_q [NUM_CELLS];
  logic [7:0] cell_cnt_q [NUM_CELLS];
  logic term_seen [NUM_TERMS];
  logic [2:0] term_cell_q [NUM_TERMS];
  logic signed [11:0] term_sig_q [NUM_TERMS];
  logic nbr_ok [NUM_TERMS][NUM_CELLS];
  logic signed [11:0] nbr_sig_q [NUM_TERMS][NUM_CELLS];

  in_word_t pending_words[$];
  out_word_t decisions_due[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  bit feed_done = 1'b0;
  int in_gap = 0, out_gap = 0;

  task automatic predict_word(input in_word_t w);
    int victim, target, bestcell, n, first;
    logic [9:0] minload;
    int best;
    out_word_t d;
    n = 0;
    first = decisions_due.size();
    case (cmd_e'(w.command))
      CMD_LOAD: begin
        cell_seen[w.cell_id] = 1'b1;
        cell_load_q[w.cell_id] = w.cell_load;
        cell_cnt_q[w.cell_id] = w.connected_count;
      end
      CMD_HDR: begin
        term_seen[w.terminal_id] = 1'b1;
        term_cell_q[w.terminal_id] = w.cell_id;
        term_sig_q[w.terminal_id] = w.signal_level;
        for (int c = 0; c < NUM_CELLS; c++) nbr_ok[w.terminal_id][c] = 1'b0;
      end
      CMD_NBR: begin
        if (term_seen[w.terminal_id]) begin
          nbr_ok[w.terminal_id][w.cell_id] = 1'b1;
          nbr_sig_q[w.terminal_id][w.cell_id] = w.signal_level;
        end
      end
      default: begin
        if (bal_en) begin
          target = -1;
          minload = FULL_LOAD;
          for (int c = 0; c < NUM_CELLS; c++)
            if (cell_seen[c] && cell_load_q[c] < minload) begin
              minload = cell_load_q[c];
              target = c;
            end
          for (int c = 0; c < NUM_CELLS; c++) begin
            if (!cell_seen[c] || cell_load_q[c] <= load_thr || cell_cnt_q[c] <= 1) continue;
            victim = -1;
            for (int t = NUM_TERMS - 1; t >= 0; t--)
              if (term_seen[t] && term_cell_q[t] == c) victim = t;
            if (victim >= 0 && target >= 0 && target != c) begin
              d = '0;
              d.decision_kind = DEC_BALANCE;
              d.moved_terminal = TERM_W'(victim);
              d.source_cell = CELL_W'(c);
              d.target_cell = CELL_W'(target);
              decisions_due.push_back(d);
              n++;
            end
          end
        end
        if (ho_en) begin
          for (int t = 0; t < NUM_TERMS; t++) begin
            if (!term_seen[t] || term_sig_q[t] >= sig_thr) continue;
            best = int'(term_sig_q[t]);
            bestcell = -1;
            for (int c = 0; c < NUM_CELLS; c++)
              if (nbr_ok[t][c] && int'(nbr_sig_q[t][c]) > best + int'(margin)) begin
                best = int'(nbr_sig_q[t][c]);
                bestcell = c;
              end
            if (bestcell >= 0) begin
              d = '0;
              d.decision_kind = DEC_HANDOVER;
              d.moved_terminal = TERM_W'(t);
              d.source_cell = term_cell_q[t];
              d.target_cell = CELL_W'(bestcell);
              decisions_due.push_back(d);
              n++;
            end
          end
        end
        if (n > 0) decisions_due[first + n - 1].last_decision = 1'b1;
      end
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_word(in_data_i);
        void'(pending_words.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        if (!(in_valid_i && in_stall_o)) in_valid_i <= 1'b0;
      end else if (in_valid_i && in_stall_o) begin
        // hold the stalled word
      end else if (pending_words.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(1, 13);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_words[0];
        end
      end else begin
        in_valid_i <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(1, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decisions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected decision %p", out_data_o);
      end else begin
        if (out_data_o !== decisions_due[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("decision mismatch: expected %p actual %p", decisions_due[0], out_data_o);
        end
        void'(decisions_due.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || decisions_due.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_LOAD_THR: load_thr = val[9:0];
      CFG_SIG_THR: sig_thr = val;
      CFG_MARGIN: margin = val[7:0];
      CFG_BAL_EN: bal_en = val[0];
      default: ho_en = val[0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_word_t mk(input cmd_e c, input int cell_no, input int load,
                                  input int cnt, input int term, input int sig);
    in_word_t w;
    w.command = c;
    w.cell_id = CELL_W'(cell_no);
    w.cell_load = 10'(load);
    w.connected_count = 8'(cnt);
    w.terminal_id = TERM_W'(term);
    w.signal_level = 12'(sig);
    return w;
  endfunction

  function automatic in_word_t rnd_word(input cmd_e c);
    in_word_t w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    w.command = c;
    w.cell_load = 10'($urandom_range(0, 1000));
    return w;
  endfunction

  task automatic random_round(input int nterm);
    int t;
    for (int c = 0; c < NUM_CELLS; c++)
      if ($urandom_range(0, 3) != 0) begin
        pending_words.push_back(mk(CMD_LOAD, c, $urandom_range(0, 1) ?
          $urandom_range(700, 1000) : $urandom_range(0, 1000), $urandom_range(0, 255),
          $urandom, $urandom));
      end
    for (int k = 0; k < nterm; k++) begin
      t = $urandom_range(0, NUM_TERMS - 1);
      pending_words.push_back(mk(CMD_HDR, $urandom_range(0, 7), $urandom, $urandom, t,
        $urandom_range(0, 3) == 0 ? $urandom : -880 - $urandom_range(0, 600)));
      for (int n = $urandom_range(0, 4); n > 0; n--)
        pending_words.push_back(mk(CMD_NBR, $urandom_range(0, 7), $urandom, $urandom,
          $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : t,
          $urandom_range(0, 3) == 0 ? $urandom : -900 + $urandom_range(0, 800)));
    end
    if ($urandom_range(0, 4) == 0) pending_words.push_back(rnd_word(cmd_e'($urandom_range(0, 2))));
    pending_words.push_back(rnd_word(CMD_TICK));
  endtask

  initial begin
    load_thr = 10'd800; sig_thr = -12'sd880; margin = 8'd24; bal_en = 1'b1; ho_en = 1'b1;
    for (int c = 0; c < NUM_CELLS; c++) begin
      cell_seen[c] = 1'b0; cell_load_q[c] = '0; cell_cnt_q[c] = '0;
    end
    for (int t = 0; t < NUM_TERMS; t++) begin
      term_seen[t] = 1'b0; term_cell_q[t] = '0; term_sig_q[t] = '0;
      for (int c = 0; c < NUM_CELLS; c++) begin
        nbr_ok[t][c] = 1'b0; nbr_sig_q[t][c] = '0;
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty tick, neighbor for unknown terminal, extremes
    pending_words.push_back(mk(CMD_TICK, 7, 1023, 255, 31, -2048));
    pending_words.push_back(mk(CMD_NBR, 3, 0, 0, 5, 2047));
    pending_words.push_back(mk(CMD_LOAD, 0, 1000, 255, 0, 0));
    pending_words.push_back(mk(CMD_LOAD, 7, 0, 0, 31, -1));
    pending_words.push_back(mk(CMD_LOAD, 2, 801, 2, 0, 0));
    pending_words.push_back(mk(CMD_LOAD, 3, 999, 1, 0, 0));
    pending_words.push_back(mk(CMD_HDR, 0, 0, 0, 31, -2048));
    pending_words.push_back(mk(CMD_NBR, 0, 0, 0, 31, -2000));
    pending_words.push_back(mk(CMD_NBR, 5, 0, 0, 31, 2047));
    pending_words.push_back(mk(CMD_HDR, 2, 0, 0, 4, -900));
    pending_words.push_back(mk(CMD_NBR, 2, 0, 0, 4, -860));
    pending_words.push_back(mk(CMD_NBR, 6, 0, 0, 4, -875));
    pending_words.push_back(mk(CMD_HDR, 2, 0, 0, 0, 2047));
    pending_words.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(CMD_HDR, 2, 0, 0, 4, -900));
    pending_words.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0));
    wait_drained();
    write_reg(CFG_LOAD_THR, 12'd0);
    write_reg(CFG_SIG_THR, 12'h7FF);
    write_reg(CFG_MARGIN, 12'd0);
    for (int k = 0; k < 4; k++) random_round(5);
    wait_drained();
    write_reg(CFG_LOAD_THR, 12'd1000);
    write_reg(CFG_SIG_THR, 12'h800);
    write_reg(CFG_MARGIN, 12'd255);
    write_reg(CFG_BAL_EN, 12'd0);
    for (int k = 0; k < 3; k++) random_round(4);
    wait_drained();
    write_reg(CFG_LOAD_THR, 12'd750);
    write_reg(CFG_SIG_THR, 12'hC40);
    write_reg(CFG_MARGIN, 12'd16);
    write_reg(CFG_BAL_EN, 12'd1);
    write_reg(CFG_HO_EN, 12'd0);
    for (int k = 0; k < 3; k++) random_round(4);
    wait_drained();
    write_reg(CFG_HO_EN, 12'd1);
    for (int k = 0; k < 3; k++) random_round(6);
    wait_drained();
    quiet = 1'b1;
    for (int k = 0; k < 3; k++) random_round(6);
    feed_done = 1'b1;
  end

  initial begin
    wait (feed_done);
    wait_drained();
    if (mismatches == 0 && decisions_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/cldh_pkg.sv
rtl/cldh_term_store.sv
rtl/cldh_nbr_store.sv
rtl/cell_load_balance_handover_decider.sv
rtl/cldh_checker.sv
test/cell_load_balance_handover_decider_tb.sv
